>>> hw/rtl/rpd_pkg.sv
// Shared types and constants for the run-length pixel pair decoder.
package rpd_pkg;

  localparam int PosW = 25;

  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_RUN_IDX   = 3'd1;
  localparam logic [2:0] PH_RUN_ALPHA = 3'd2;
  localparam logic [2:0] PH_LIT_IDX   = 3'd3;
  localparam logic [2:0] PH_LIT_ALPHA = 3'd4;

  localparam logic [7:0] RUN_FLAG = 8'h80;
  localparam logic [7:0] LEN_MASK = 8'h7F;

  typedef struct packed {
    logic [2:0]      phase;
    logic [7:0]      packet_remaining;
    logic [7:0]      held_index;
    logic [PosW-1:0] pixel_position;
    logic            finished;
  } state_t;

  typedef struct packed {
    logic [7:0]  palette_index;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic [23:0] first_pixel;
    logic        image_done;
  } result_t;

endpackage

>>> hw/rtl/rle_pixel_pair_decoder.sv
// Top level of the packbits-style run-length pixel pair decoder.
// Takes one compressed byte per cycle when not stalled, and gives one result per
// completed run or literal pixel; a byte is captured in the input register and
// decoded into the result register when it advances. The sustained rate is one
// byte per clock, set by the single decode stage between the input register and
// the result register; while a result is held by pixel_stall the byte in the
// input register waits, and the input stalls.
module rle_pixel_pair_decoder #(
  parameter int MAX_PIXELS = 16777216
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_total_we,
  input  logic [24:0] pixel_total,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_image,
  output logic        pixel_valid,
  input  logic        pixel_stall,
  output logic [7:0]  palette_index,
  output logic [7:0]  alpha,
  output logic [7:0]  repeat_count,
  output logic [23:0] first_pixel,
  output logic        image_done
);

  logic [24:0]      total;
  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic             hold_start;
  rpd_pkg::state_t  state;
  rpd_pkg::state_t  state_next;
  rpd_pkg::result_t res;
  rpd_pkg::result_t out_reg;
  logic             emit;
  logic             advance;

  assign advance    = hold_valid && (!pixel_valid || !pixel_stall);
  assign byte_stall = hold_valid && !advance;

  rpd_step #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_step (
    .cur        (state),
    .data_byte  (hold_byte),
    .start_image(hold_start),
    .pixel_total(total),
    .nxt        (state_next),
    .emit       (emit),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (pixel_total_we) begin
      total <= pixel_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!byte_stall) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      hold_byte  <= data_byte;
      hold_start <= start_image;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase            <= rpd_pkg::PH_HEADER;
      state.packet_remaining <= '0;
      state.held_index       <= '0;
      state.pixel_position   <= '0;
      state.finished         <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (advance && emit) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_reg <= res;
    end
  end

  assign palette_index = out_reg.palette_index;
  assign alpha         = out_reg.alpha;
  assign repeat_count  = out_reg.repeat_count;
  assign first_pixel   = out_reg.first_pixel;
  assign image_done    = out_reg.image_done;

endmodule

>>> hw/rtl/rpd_step.sv
// Next-state and result logic for one compressed byte.
module rpd_step #(
  parameter int MAX_PIXELS = 16777216
) (
  input  rpd_pkg::state_t              cur,
  input  logic [7:0]                   data_byte,
  input  logic                         start_image,
  input  logic [rpd_pkg::PosW-1:0]     pixel_total,
  output rpd_pkg::state_t              nxt,
  output logic                         emit,
  output rpd_pkg::result_t             res
);

  localparam logic [rpd_pkg::PosW-1:0] MaxPix = rpd_pkg::PosW'(MAX_PIXELS);

  rpd_pkg::state_t             base;
  logic [rpd_pkg::PosW-1:0]    limit;
  logic [rpd_pkg::PosW-1:0]    left;
  logic [rpd_pkg::PosW-1:0]    pos_sum;
  logic [7:0]                  want;
  logic [7:0]                  cnt;
  logic [7:0]                  alpha_b;
  logic [7:0]                  lit_left;
  logic                        do_emit;

  always_comb begin
    base = cur;
    if (start_image) begin
      base.phase            = rpd_pkg::PH_HEADER;
      base.packet_remaining = '0;
      base.held_index       = '0;
      base.pixel_position   = '0;
      base.finished         = 1'b0;
    end
    limit = (pixel_total > MaxPix) ? MaxPix : pixel_total;
    if (base.pixel_position >= limit) begin
      base.finished = 1'b1;
    end

    nxt      = base;
    do_emit  = 1'b0;
    want     = 8'd1;
    alpha_b  = data_byte;
    lit_left = (base.packet_remaining != 8'd0) ? base.packet_remaining - 8'd1 : 8'd0;

    if (!base.finished) begin
      unique case (base.phase)
        rpd_pkg::PH_HEADER: begin
          nxt.packet_remaining = (data_byte & rpd_pkg::LEN_MASK) + 8'd1;
          nxt.phase = ((data_byte & rpd_pkg::RUN_FLAG) != 8'd0) ?
                      rpd_pkg::PH_RUN_IDX : rpd_pkg::PH_LIT_IDX;
        end
        rpd_pkg::PH_RUN_IDX: begin
          nxt.held_index = data_byte;
          nxt.phase      = rpd_pkg::PH_RUN_ALPHA;
        end
        rpd_pkg::PH_RUN_ALPHA: begin
          nxt.phase = rpd_pkg::PH_HEADER;
          want      = base.packet_remaining;
          do_emit   = 1'b1;
        end
        rpd_pkg::PH_LIT_IDX: begin
          nxt.held_index = data_byte;
          nxt.phase      = rpd_pkg::PH_LIT_ALPHA;
        end
        rpd_pkg::PH_LIT_ALPHA: begin
          nxt.packet_remaining = lit_left;
          nxt.phase = (lit_left == 8'd0) ? rpd_pkg::PH_HEADER : rpd_pkg::PH_LIT_IDX;
          do_emit   = 1'b1;
        end
        default: begin
          nxt.phase = rpd_pkg::PH_HEADER;
        end
      endcase
    end

    left = limit - base.pixel_position;
    cnt  = ({{(rpd_pkg::PosW-8){1'b0}}, want} > left) ? left[7:0] : want;
    pos_sum = base.pixel_position + {{(rpd_pkg::PosW-8){1'b0}}, cnt};
    if (do_emit) begin
      nxt.pixel_position = pos_sum;
      nxt.finished       = (pos_sum >= limit);
    end

    emit              = do_emit;
    res.palette_index = base.held_index;
    res.alpha         = alpha_b;
    res.repeat_count  = cnt;
    res.first_pixel   = base.pixel_position[23:0];
    res.image_done    = (pos_sum >= limit);
  end

endmodule
